FILE: src/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// shared widths, action codes and saturation helper for the box accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package bba_pkg;
	localparam int CW = 32;
	localparam int PW = 64;
	localparam int AW = 66;

	localparam logic [2:0] ACT_CLEAR  = 3'd0;
	localparam logic [2:0] ACT_ADD    = 3'd1;
	localparam logic [2:0] ACT_MERGE  = 3'd2;
	localparam logic [2:0] ACT_MOVE   = 3'd3;
	localparam logic [2:0] ACT_ROTATE = 3'd4;

	localparam logic signed [AW-1:0] SAT_MAX = 66'sd2147483647;
	localparam logic signed [AW-1:0] SAT_MIN = -66'sd2147483648;

	typedef logic signed [CW-1:0] coord_t;

	function automatic coord_t sat32(input logic signed [AW-1:0] v);
		coord_t r;
		if (v > SAT_MAX) begin
			r = coord_t'(SAT_MAX[CW-1:0]);
		end else if (v < SAT_MIN) begin
			r = coord_t'(SAT_MIN[CW-1:0]);
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

FILE: src/bba_mul.sv
// ----------------------------------------------------------------------------
// bba_mul
// shared signed 32 x 32 multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none
module bba_mul (
	input  wire                                 clk,
	input  wire  bba_pkg::coord_t               a,
	input  wire  bba_pkg::coord_t               b,
	output logic signed [bba_pkg::PW-1:0]       p_q
);
	always_ff @(posedge clk) begin
		p_q <= bba_pkg::PW'(a) * bba_pkg::PW'(b);
	end
endmodule
`default_nettype wire

FILE: src/bounding_box_accumulator.sv
// ----------------------------------------------------------------------------
// bounding_box_accumulator
// 3d axis-aligned box in q15.16 with clear, add, merge, translate, rotate
// ----------------------------------------------------------------------------
// Each item returns the box after its action. Clear, add, merge, translate
// and unused codes are applied at accept. Rotate of a non-empty box runs
// on one shared 32x32 multiplier: 10 quaternion products, a matrix step,
// then 8 corners x 3 axes x 3 terms = 72 products. The input is ready
// whenever the sequencer is idle, even while a result waits.
`default_nettype none
module bounding_box_accumulator (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	// in_x, in_y, in_z, hi_x, hi_y, hi_z, quat_w, zero pad
	input  wire  [215:0]  s_tdata,
	// action
	input  wire  [2:0]    s_tuser,
	output logic          m_tvalid,
	input  wire           m_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z, half_x, half_y, half_z, pad
	output logic [287:0]  m_tdata,
	// is_empty
	output logic          m_tuser
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MAT  = 3'd1;
	localparam logic [2:0] ST_MATB = 3'd2;
	localparam logic [2:0] ST_CORN = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0] state_q;
	logic empty_q;
	bba_pkg::coord_t mn_q [3];
	bba_pkg::coord_t mx_q [3];
	bba_pkg::coord_t lo_q [3];
	bba_pkg::coord_t hi_q [3];
	bba_pkg::coord_t q_q [4];
	logic signed [47:0] p_q [10];
	bba_pkg::coord_t m_q [3][3];
	bba_pkg::coord_t tv_q [2];
	logic signed [bba_pkg::AW-1:0] acc_q;

	logic [3:0] cnt_q;
	logic mv_s1;
	logic [3:0] midx_s1;
	logic issue_q;
	logic [2:0] cn_q;
	logic [1:0] ck_q, ct_q;
	logic cv_s1, last_s1;
	logic [1:0] ck_s1, ct_s1;

	bba_pkg::coord_t mul_a, mul_b;
	logic signed [bba_pkg::PW-1:0] prod;

	bba_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_q(prod));

	bba_pkg::coord_t ix [3];
	bba_pkg::coord_t hx [3];
	assign ix[0] = s_tdata[31:0];
	assign ix[1] = s_tdata[63:32];
	assign ix[2] = s_tdata[95:64];
	assign hx[0] = s_tdata[127:96];
	assign hx[1] = s_tdata[159:128];
	assign hx[2] = s_tdata[191:160];

	assign s_tready = (state_q == ST_IDLE);

	// operand select
	always_comb begin
		mul_a = q_q[0];
		mul_b = q_q[0];
		if (state_q == ST_MAT) begin
			unique case (cnt_q)
				4'd0: begin mul_a = q_q[3]; mul_b = q_q[3]; end
				4'd1: begin mul_a = q_q[0]; mul_b = q_q[0]; end
				4'd2: begin mul_a = q_q[1]; mul_b = q_q[1]; end
				4'd3: begin mul_a = q_q[2]; mul_b = q_q[2]; end
				4'd4: begin mul_a = q_q[0]; mul_b = q_q[1]; end
				4'd5: begin mul_a = q_q[0]; mul_b = q_q[2]; end
				4'd6: begin mul_a = q_q[1]; mul_b = q_q[2]; end
				4'd7: begin mul_a = q_q[3]; mul_b = q_q[0]; end
				4'd8: begin mul_a = q_q[3]; mul_b = q_q[1]; end
				default: begin mul_a = q_q[3]; mul_b = q_q[2]; end
			endcase
		end else begin
			mul_a = m_q[ck_q][ct_q];
			mul_b = cn_q[ct_q] ? hi_q[ct_q] : lo_q[ct_q];
		end
	end

	// matrix from products
	logic signed [50:0] e [10];
	logic signed [50:0] sm [9];
	always_comb begin
		for (int i = 0; i < 10; i++) e[i] = 51'(p_q[i]);
		sm[0] = e[0] + e[1] - e[2] - e[3];
		sm[1] = (e[4] - e[9]) <<< 1;
		sm[2] = (e[5] + e[8]) <<< 1;
		sm[3] = (e[4] + e[9]) <<< 1;
		sm[4] = e[0] - e[1] + e[2] - e[3];
		sm[5] = (e[6] - e[7]) <<< 1;
		sm[6] = (e[5] - e[8]) <<< 1;
		sm[7] = (e[6] + e[7]) <<< 1;
		sm[8] = e[0] - e[1] - e[2] + e[3];
	end

	logic signed [bba_pkg::AW-1:0] sum;
	bba_pkg::coord_t tnew;
	bba_pkg::coord_t pt [3];
	assign sum = ((ct_s1 == 2'd0) ? '0 : acc_q) + bba_pkg::AW'(prod);
	assign tnew = bba_pkg::sat32(sum >>> 16);
	assign pt[0] = tv_q[0];
	assign pt[1] = tv_q[1];
	assign pt[2] = tnew;

	logic signed [32:0] dif [3];
	logic [30:0] hv [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dif[k] = 33'(mx_q[k]) - 33'(mn_q[k]);
			hv[k] = dif[k][32] ? 31'd0 : dif[k][31:1];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			q_q[0] <= ix[0];
			q_q[1] <= ix[1];
			q_q[2] <= ix[2];
			q_q[3] <= 32'(signed'(s_tdata[209:192]));
			for (int k = 0; k < 3; k++) begin
				lo_q[k] <= mn_q[k];
				hi_q[k] <= mx_q[k];
			end
		end
		if (mv_s1) p_q[midx_s1] <= prod[63:16];
		if (state_q == ST_MATB) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					m_q[i][j] <= bba_pkg::sat32(bba_pkg::AW'(sm[i*3+j]));
		end
		if (cv_s1) begin
			acc_q <= sum;
			if (ct_s1 == 2'd2 && ck_s1 != 2'd2) tv_q[ck_s1[0]] <= tnew;
		end
		if (state_q == ST_FIN && (!m_tvalid || m_tready)) begin
			m_tuser <= empty_q;
			m_tdata <= {3'd0, hv[2], hv[1], hv[0], mx_q[2], mx_q[1], mx_q[0],
				mn_q[2], mn_q[1], mn_q[0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			empty_q <= 1'b1;
			for (int k = 0; k < 3; k++) begin
				mn_q[k] <= '0;
				mx_q[k] <= '0;
			end
			cnt_q <= '0;
			mv_s1 <= 1'b0;
			midx_s1 <= '0;
			issue_q <= 1'b0;
			cn_q <= '0;
			ck_q <= '0;
			ct_q <= '0;
			cv_s1 <= 1'b0;
			last_s1 <= 1'b0;
			ck_s1 <= '0;
			ct_s1 <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_FIN) m_tvalid <= 1'b0;
			mv_s1 <= (state_q == ST_MAT) && (cnt_q <= 4'd9);
			midx_s1 <= cnt_q;
			cv_s1 <= (state_q == ST_CORN) && issue_q;
			ck_s1 <= ck_q;
			ct_s1 <= ct_q;
			last_s1 <= (cn_q == 3'd7) && (ck_q == 2'd2) && (ct_q == 2'd2);
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= (s_tuser == bba_pkg::ACT_ROTATE && !empty_q) ?
							ST_MAT : ST_FIN;
						unique case (s_tuser)
							bba_pkg::ACT_CLEAR: begin
								empty_q <= 1'b1;
								for (int k = 0; k < 3; k++) begin
									mn_q[k] <= '0;
									mx_q[k] <= '0;
								end
							end
							bba_pkg::ACT_ADD: begin
								empty_q <= 1'b0;
								for (int k = 0; k < 3; k++) begin
									if (empty_q || ix[k] < mn_q[k]) mn_q[k] <= ix[k];
									if (empty_q || ix[k] > mx_q[k]) mx_q[k] <= ix[k];
								end
							end
							bba_pkg::ACT_MERGE: begin
								empty_q <= 1'b0;
								for (int k = 0; k < 3; k++) begin
									if (empty_q || ix[k] < mn_q[k]) mn_q[k] <= ix[k];
									if (empty_q || hx[k] > mx_q[k]) mx_q[k] <= hx[k];
								end
							end
							bba_pkg::ACT_MOVE: begin
								if (!empty_q) begin
									for (int k = 0; k < 3; k++) begin
										mn_q[k] <= bba_pkg::sat32(bba_pkg::AW'(mn_q[k])
											+ bba_pkg::AW'(ix[k]));
										mx_q[k] <= bba_pkg::sat32(bba_pkg::AW'(mx_q[k])
											+ bba_pkg::AW'(ix[k]));
									end
								end
							end
							bba_pkg::ACT_ROTATE: begin
								if (!empty_q) begin
									cnt_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_MAT: begin
					if (cnt_q <= 4'd9) cnt_q <= cnt_q + 4'd1;
					if (mv_s1 && midx_s1 == 4'd9) state_q <= ST_MATB;
				end
				ST_MATB: begin
					state_q <= ST_CORN;
					issue_q <= 1'b1;
					cn_q <= '0;
					ck_q <= '0;
					ct_q <= '0;
					empty_q <= 1'b1;
				end
				ST_CORN: begin
					if (issue_q) begin
						if (ct_q != 2'd2) begin
							ct_q <= ct_q + 2'd1;
						end else begin
							ct_q <= '0;
							if (ck_q != 2'd2) begin
								ck_q <= ck_q + 2'd1;
							end else begin
								ck_q <= '0;
								if (cn_q == 3'd7) issue_q <= 1'b0;
								else cn_q <= cn_q + 3'd1;
							end
						end
					end
					if (cv_s1 && ct_s1 == 2'd2 && ck_s1 == 2'd2) begin
						empty_q <= 1'b0;
						for (int k = 0; k < 3; k++) begin
							if (empty_q || pt[k] < mn_q[k]) mn_q[k] <= pt[k];
							if (empty_q || pt[k] > mx_q[k]) mx_q[k] <= pt[k];
						end
						if (last_s1) state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives clear, add, merge, translate, rotate and unused-code items into the box
// accumulator, predicts each returned box in a local model and compares
// corners, half sizes and the empty flag of every result item
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	localparam logic [2:0] ACT_SPARE = 3'd5;
	localparam int QUIET_LIMIT = 20000;

	typedef struct packed {
		logic        is_empty;
		logic [30:0] hf_z, hf_y, hf_x;
		logic [31:0] up_z, up_y, up_x, lo_z, lo_y, lo_x;
	} box_view_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [215:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [287:0] m_tdata;
	logic m_tuser;

	bounding_box_accumulator dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	longint box_lo[3], box_hi[3];
	bit box_void;
	box_view_t pending_boxes[$];
	int mismatches = 0;
	int quiet_cycles = 0;
	bit sender_calm = 0;
	bit hold_receiver = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint qprod(longint a, longint b);
		return (a * b) >>> 16;
	endfunction

	function automatic void take_point(longint p[3]);
		if (box_void) begin
			for (int k = 0; k < 3; k++) begin
				box_lo[k] = p[k];
				box_hi[k] = p[k];
			end
			box_void = 0;
		end else begin
			for (int k = 0; k < 3; k++) begin
				if (p[k] < box_lo[k]) box_lo[k] = p[k];
				if (p[k] > box_hi[k]) box_hi[k] = p[k];
			end
		end
	endfunction

	function automatic void turn_box(longint x, longint y, longint z, longint w);
		longint m[3][3];
		longint lo[3], hi[3], c[3], t[3];
		logic signed [127:0] acc;
		longint ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;
		ww = qprod(w, w); xx = qprod(x, x); yy = qprod(y, y); zz = qprod(z, z);
		xy = qprod(x, y); xz = qprod(x, z); yz = qprod(y, z);
		wx = qprod(w, x); wy = qprod(w, y); wz = qprod(w, z);
		m[0][0] = clamp32(ww + xx - yy - zz);
		m[0][1] = clamp32(2 * (xy - wz));
		m[0][2] = clamp32(2 * (xz + wy));
		m[1][0] = clamp32(2 * (xy + wz));
		m[1][1] = clamp32(ww - xx + yy - zz);
		m[1][2] = clamp32(2 * (yz - wx));
		m[2][0] = clamp32(2 * (xz - wy));
		m[2][1] = clamp32(2 * (yz + wx));
		m[2][2] = clamp32(ww - xx - yy + zz);
		lo = box_lo;
		hi = box_hi;
		box_void = 1;
		for (int n = 0; n < 8; n++) begin
			for (int k = 0; k < 3; k++) c[k] = ((n >> k) & 1) ? hi[k] : lo[k];
			for (int k = 0; k < 3; k++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) acc += 128'(m[k][j]) * 128'(c[j]);
				acc = acc >>> 16;
				if (acc > 128'sd2147483647) t[k] = 64'sd2147483647;
				else if (acc < -128'sd2147483648) t[k] = -64'sd2147483648;
				else t[k] = longint'(acc);
			end
			take_point(t);
		end
	endfunction

	function automatic box_view_t predict_box(logic [2:0] act, logic [215:0] d);
		longint a[3], b[3], h[3];
		box_view_t r;
		for (int k = 0; k < 3; k++) begin
			a[k] = longint'($signed(d[32*k +: 32]));
			b[k] = longint'($signed(d[96 + 32*k +: 32]));
		end
		case (act)
			bba_pkg::ACT_CLEAR: begin
				box_lo = '{0, 0, 0};
				box_hi = '{0, 0, 0};
				box_void = 1;
			end
			bba_pkg::ACT_ADD: take_point(a);
			bba_pkg::ACT_MERGE: begin
				if (box_void) begin
					box_lo = a;
					box_hi = b;
					box_void = 0;
				end else begin
					for (int k = 0; k < 3; k++) begin
						if (a[k] < box_lo[k]) box_lo[k] = a[k];
						if (b[k] > box_hi[k]) box_hi[k] = b[k];
					end
				end
			end
			bba_pkg::ACT_MOVE: if (!box_void) begin
				for (int k = 0; k < 3; k++) begin
					box_lo[k] = clamp32(box_lo[k] + a[k]);
					box_hi[k] = clamp32(box_hi[k] + a[k]);
				end
			end
			bba_pkg::ACT_ROTATE: if (!box_void)
				turn_box(a[0], a[1], a[2], longint'($signed(d[192 +: 18])));
			default: ;
		endcase
		for (int k = 0; k < 3; k++) begin
			h[k] = (box_hi[k] - box_lo[k]) >>> 1;
			if (h[k] < 0) h[k] = 0;
		end
		r.is_empty = box_void;
		r.lo_x = box_lo[0][31:0]; r.lo_y = box_lo[1][31:0]; r.lo_z = box_lo[2][31:0];
		r.up_x = box_hi[0][31:0]; r.up_y = box_hi[1][31:0]; r.up_z = box_hi[2][31:0];
		r.hf_x = h[0][30:0]; r.hf_y = h[1][30:0]; r.hf_z = h[2][30:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
		mismatches++;
	endtask

	task automatic send_item(logic [2:0] act, logic [31:0] p[3], logic [31:0] q[3],
			logic [17:0] w);
		int gap;
		if (!sender_calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= {6'd0, w, q[2], q[1], q[0], p[2], p[1], p[0]};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_boxes.push_back(predict_box(s_tuser, s_tdata));
	endtask

	function automatic logic [31:0] pick_coord();
		case ($urandom_range(0, 7))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
			3, 4: return 32'($signed($urandom_range(0, 400000)) - 200000) <<< 4;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [17:0] pick_w();
		case ($urandom_range(0, 4))
			0: return 18'h10000;
			1: return 18'h30000;
			2: return 18'($signed($urandom_range(0, 131072)) - 65536);
			default: return 18'($urandom);
		endcase
	endfunction

	task automatic send_random(int count);
		logic [31:0] p[3], q[3];
		logic [2:0] act;
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++) begin
				p[k] = pick_coord();
				q[k] = pick_coord();
			end
			case ($urandom_range(0, 19))
				0: act = bba_pkg::ACT_CLEAR;
				1, 2, 3, 4, 5, 6: act = bba_pkg::ACT_ADD;
				7, 8, 9, 10: act = bba_pkg::ACT_MERGE;
				11, 12, 13, 14: act = bba_pkg::ACT_MOVE;
				15, 16, 17: act = bba_pkg::ACT_ROTATE;
				default: act = 3'($urandom_range(ACT_SPARE, 7));
			endcase
			if (act == bba_pkg::ACT_ROTATE && $urandom_range(0, 1)) begin
				for (int k = 0; k < 3; k++) p[k] = 32'($signed($urandom_range(0, 131072)) - 65536);
			end
			send_item(act, p, q, pick_w());
		end
	endtask

	task automatic test_directed();
		logic [31:0] z[3], mx[3], mn[3], one[3];
		z = '{0, 0, 0};
		mx = '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff};
		mn = '{32'h80000000, 32'h80000000, 32'h80000000};
		one = '{32'h10000, 32'h20000, 32'hfffd0000};
		send_item(bba_pkg::ACT_MOVE, one, z, 18'd0);
		send_item(bba_pkg::ACT_ROTATE, one, z, 18'h10000);
		send_item(bba_pkg::ACT_ADD, one, z, 18'd0);
		send_item(bba_pkg::ACT_ADD, mx, z, 18'd0);
		send_item(bba_pkg::ACT_ADD, mn, z, 18'd0);
		send_item(bba_pkg::ACT_MOVE, mx, z, 18'd0);
		send_item(bba_pkg::ACT_MOVE, mn, z, 18'd0);
		send_item(bba_pkg::ACT_CLEAR, z, z, 18'd0);
		send_item(bba_pkg::ACT_MERGE, mx, mn, 18'd0);
		send_item(bba_pkg::ACT_MERGE, one, one, 18'd0);
		send_item(bba_pkg::ACT_CLEAR, mx, mx, 18'h3ffff);
		send_item(bba_pkg::ACT_MERGE, mn, mx, 18'd0);
		send_item(bba_pkg::ACT_CLEAR, z, z, 18'd0);
		send_item(bba_pkg::ACT_ADD, one, z, 18'd0);
		send_item(bba_pkg::ACT_ADD, z, z, 18'd0);
		send_item(bba_pkg::ACT_ROTATE, z, z, 18'h10000);
		send_item(bba_pkg::ACT_ROTATE, '{32'h10000, 0, 0}, z, 18'd0);
		send_item(bba_pkg::ACT_ROTATE, '{32'h0b505, 32'h0b505, 0}, z, 18'h20000);
		send_item(bba_pkg::ACT_ROTATE, mx, z, 18'h1ffff);
		send_item(bba_pkg::ACT_ROTATE, mn, mx, 18'h20000);
		send_item(bba_pkg::ACT_ROTATE, z, z, 18'd0);
		send_item(ACT_SPARE, mx, mn, 18'h3ffff);
		send_item(3'd7, mn, mx, 18'h2aaaa);
		send_item(3'd6, z, z, 18'h15555);
	endtask

	task automatic test_backpressure();
		hold_receiver = 1;
		send_random(12);
		hold_receiver = 0;
	endtask

	task automatic test_random();
		send_random(1350);
		sender_calm = 1;
		send_random(150);
	endtask

	initial begin
		box_lo = '{0, 0, 0};
		box_hi = '{0, 0, 0};
		box_void = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		while (pending_boxes.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		int stall;
		int held;
		forever begin
			@(posedge clk);
			if (hold_receiver) begin
				held = 0;
				m_tready <= 1'b0;
				while (held < 400) begin
					@(posedge clk);
					held++;
				end
				m_tready <= 1'b1;
			end else if (!sender_calm && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 4);
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	initial begin
		box_view_t got, want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = {m_tuser, m_tdata[284:0]};
				if (pending_boxes.size() == 0) begin
					report_mismatch("unexpected item", 32'(m_tuser), 0);
				end else begin
					want = pending_boxes.pop_front();
					if (got.is_empty != want.is_empty)
						report_mismatch("is_empty", 32'(got.is_empty), 32'(want.is_empty));
					if (got.lo_x != want.lo_x) report_mismatch("min_x", got.lo_x, want.lo_x);
					if (got.lo_y != want.lo_y) report_mismatch("min_y", got.lo_y, want.lo_y);
					if (got.lo_z != want.lo_z) report_mismatch("min_z", got.lo_z, want.lo_z);
					if (got.up_x != want.up_x) report_mismatch("max_x", got.up_x, want.up_x);
					if (got.up_y != want.up_y) report_mismatch("max_y", got.up_y, want.up_y);
					if (got.up_z != want.up_z) report_mismatch("max_z", got.up_z, want.up_z);
					if (got.hf_x != want.hf_x) report_mismatch("half_x", 32'(got.hf_x), 32'(want.hf_x));
					if (got.hf_y != want.hf_y) report_mismatch("half_y", 32'(got.hf_y), 32'(want.hf_y));
					if (got.hf_z != want.hf_z) report_mismatch("half_z", 32'(got.hf_z), 32'(want.hf_z));
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end
endmodule
`default_nettype wire
